@@ sv/pcg_pkg.sv @@
// ----------------------------------------------------------------------------
// PCG32 generator package
// Shared constants, command and status types for controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pcg_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned StateW   = 64;
    localparam int unsigned DivSteps = WordW;
    localparam int unsigned CntW     = $clog2(DivSteps);

    localparam logic [StateW-1:0] PcgMult = 64'd6364136223846793005;

    // request codes
    localparam logic [1:0] OP_RAW32 = 2'd0;
    localparam logic [1:0] OP_RAW64 = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;

    // LCG update steps on the shared 32x32 multiplier
    typedef enum logic [2:0] {
        MS_NONE,
        MS_P0,
        MS_P1,
        MS_P2,
        MS_UPD
    } t_mstep;

    // result accumulator loads
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_ZERO,
        ACC_LOWIN,
        ACC_WORD,
        ACC_HI,
        ACC_LO,
        ACC_MOD
    } t_acc;

    typedef struct packed {
        logic   load_seed;
        logic   clear_state;
        logic   add_seed;
        logic   cap_in;
        t_mstep mstep;
        t_acc   acc;
        logic   div_init;
        logic   div_step;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full_range;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/pcg_dp.sv @@
// ----------------------------------------------------------------------------
// PCG32 datapath
// LCG state with a shared 32x32 multiplier, XSH-RR output, serial modulo.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pcg_pkg::t_cmd                 i_cmd,
    output pcg_pkg::t_sts                      o_sts,
    input  wire logic [pcg_pkg::StateW-1:0]    i_seed_value,
    input  wire logic [1:0]                    i_operation,
    input  wire logic signed [pcg_pkg::WordW-1:0] i_range_low,
    input  wire logic signed [pcg_pkg::WordW-1:0] i_range_high,
    output logic [pcg_pkg::StateW-1:0]         o_random_value
);

    localparam int unsigned W = pcg_pkg::WordW;
    localparam int unsigned S = pcg_pkg::StateW;

    logic [S-1:0]   r_seed;
    logic [S-1:0]   r_lcg;
    logic [S-1:0]   r_prod0;
    logic [W-1:0]   r_cross;
    logic [W-1:0]   r_word;
    logic [S-1:0]   r_acc;
    logic [S-1:0]   r_out;
    logic [1:0]     r_op;
    logic [W-1:0]   r_low;
    logic [W-1:0]   r_high;
    logic [W-1:0]   r_size;
    logic [W-1:0]   r_dvd;
    logic [W-1:0]   r_rem;

    logic [S-1:0]   inc;
    logic [W-1:0]   mul_a;
    logic [W-1:0]   mul_b;
    logic [S-1:0]   prod;
    logic [S-1:0]   xsh;
    logic [W-1:0]   xs;
    logic [4:0]     rot;
    logic [2*W-1:0] rot_dbl;
    logic [W-1:0]   out_word;
    logic [W:0]     trial;
    logic [W:0]     trial_sub;

    assign inc = {r_seed[S-2:0], 1'b1};

    // operand select for the partial products of state * multiplier
    always_comb begin
        mul_a = r_lcg[W-1:0];
        mul_b = pcg_pkg::PcgMult[W-1:0];
        case (i_cmd.mstep)
            pcg_pkg::MS_P1: begin
                mul_a = r_lcg[S-1:W];
            end
            pcg_pkg::MS_P2: begin
                mul_b = pcg_pkg::PcgMult[S-1:W];
            end
            default: begin
            end
        endcase
    end

    assign prod = S'(mul_a) * S'(mul_b);

    // XSH-RR output from the current state
    assign xsh      = (r_lcg >> 18) ^ r_lcg;
    assign xs       = xsh[W+26:27];
    assign rot      = r_lcg[S-1:S-5];
    assign rot_dbl  = {xs, xs} >> rot;
    assign out_word = rot_dbl[W-1:0];

    // restoring remainder step
    assign trial     = {r_rem, r_dvd[W-1]};
    assign trial_sub = trial - {1'b0, r_size};

    assign o_sts.op         = r_op;
    assign o_sts.empty      = $signed(r_low) >= $signed(r_high);
    assign o_sts.full_range = (r_size == '0);
    assign o_random_value   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cmd.load_seed) begin
            r_seed <= i_seed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_state) begin
            r_lcg <= '0;
        end else if (i_cmd.add_seed) begin
            r_lcg <= r_lcg + r_seed;
        end else if (i_cmd.mstep == pcg_pkg::MS_UPD) begin
            r_lcg <= r_prod0 + {r_cross, {W{1'b0}}} + inc;
        end

        case (i_cmd.mstep)
            pcg_pkg::MS_P0: begin
                r_prod0 <= prod;
                r_word  <= out_word;
            end
            pcg_pkg::MS_P1: begin
                r_cross <= prod[W-1:0];
            end
            pcg_pkg::MS_P2: begin
                r_cross <= r_cross + prod[W-1:0];
            end
            default: begin
            end
        endcase

        if (i_cmd.cap_in) begin
            r_op   <= i_operation;
            r_low  <= i_range_low;
            r_high <= i_range_high;
            r_size <= i_range_high - i_range_low + W'(1);
        end

        if (i_cmd.div_init) begin
            r_dvd <= r_word;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            if (!trial_sub[W]) begin
                r_rem <= trial_sub[W-1:0];
            end else begin
                r_rem <= trial[W-1:0];
            end
        end

        case (i_cmd.acc)
            pcg_pkg::ACC_ZERO:  r_acc <= '0;
            pcg_pkg::ACC_LOWIN: r_acc <= {{W{1'b0}}, r_low};
            pcg_pkg::ACC_WORD:  r_acc <= {{W{1'b0}}, r_word};
            pcg_pkg::ACC_HI:    r_acc[S-1:W] <= r_word;
            pcg_pkg::ACC_LO:    r_acc[W-1:0] <= r_word;
            pcg_pkg::ACC_MOD:   r_acc <= {{W{1'b0}}, r_low + r_rem};
            default: begin
            end
        endcase

        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

endmodule

`default_nettype wire

@@ sv/pcg_ctrl.sv @@
// ----------------------------------------------------------------------------
// PCG32 controller
// Sequences seeding, draws, the serial modulo and the output handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg_ctrl (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    output logic        o_valid,
    input  wire logic   i_ready,
    input  wire logic   i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire pcg_pkg::t_sts i_sts,
    output pcg_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED0,
        S_ADDSEED,
        S_DECODE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_UPD,
        S_DIV,
        S_DIVEND,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        K_SEED_A,
        K_SEED_B,
        K_RAW32,
        K_HI,
        K_LO,
        K_RANGE
    } t_kind;

    t_state                   r_state, n_state;
    t_kind                    r_kind, n_kind;
    logic [pcg_pkg::CntW-1:0] r_cnt, n_cnt;
    logic                     r_out_valid, n_out_valid;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_valid     = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_cnt   = r_cnt;
        o_cmd   = '{
            load_seed:   1'b0,
            clear_state: 1'b0,
            add_seed:    1'b0,
            cap_in:      1'b0,
            mstep:       pcg_pkg::MS_NONE,
            acc:         pcg_pkg::ACC_HOLD,
            div_init:    1'b0,
            div_step:    1'b0,
            out_load:    1'b0
        };

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    o_cmd.load_seed = 1'b1;
                    n_state         = S_SEED0;
                end else if (i_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_SEED0: begin
                o_cmd.clear_state = 1'b1;
                n_kind            = K_SEED_A;
                n_state           = S_MUL0;
            end
            S_ADDSEED: begin
                o_cmd.add_seed = 1'b1;
                n_kind         = K_SEED_B;
                n_state        = S_MUL0;
            end
            S_DECODE: begin
                case (i_sts.op)
                    pcg_pkg::OP_RAW32: begin
                        n_kind  = K_RAW32;
                        n_state = S_MUL0;
                    end
                    pcg_pkg::OP_RAW64: begin
                        n_kind  = K_HI;
                        n_state = S_MUL0;
                    end
                    pcg_pkg::OP_RANGE: begin
                        if (i_sts.empty) begin
                            o_cmd.acc = pcg_pkg::ACC_LOWIN;
                            n_state   = S_FIN;
                        end else begin
                            n_kind  = K_RANGE;
                            n_state = S_MUL0;
                        end
                    end
                    default: begin
                        o_cmd.acc = pcg_pkg::ACC_ZERO;
                        n_state   = S_FIN;
                    end
                endcase
            end
            S_MUL0: begin
                o_cmd.mstep = pcg_pkg::MS_P0;
                n_state     = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mstep = pcg_pkg::MS_P1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mstep = pcg_pkg::MS_P2;
                n_state     = S_UPD;
            end
            S_UPD: begin
                o_cmd.mstep = pcg_pkg::MS_UPD;
                unique case (r_kind)
                    K_SEED_A: n_state = S_ADDSEED;
                    K_SEED_B: n_state = S_IDLE;
                    K_RAW32: begin
                        o_cmd.acc = pcg_pkg::ACC_WORD;
                        n_state   = S_FIN;
                    end
                    K_HI: begin
                        o_cmd.acc = pcg_pkg::ACC_HI;
                        n_kind    = K_LO;
                        n_state   = S_MUL0;
                    end
                    K_LO: begin
                        o_cmd.acc = pcg_pkg::ACC_LO;
                        n_state   = S_FIN;
                    end
                    K_RANGE: begin
                        // full 2^32 range: hand back the raw word
                        if (i_sts.full_range) begin
                            o_cmd.acc = pcg_pkg::ACC_WORD;
                            n_state   = S_FIN;
                        end else begin
                            o_cmd.div_init = 1'b1;
                            n_cnt          = '0;
                            n_state        = S_DIV;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == pcg_pkg::CntW'(pcg_pkg::DivSteps - 1)) begin
                    n_state = S_DIVEND;
                end
            end
            S_DIVEND: begin
                o_cmd.acc = pcg_pkg::ACC_MOD;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SEED0;
            r_kind      <= K_SEED_A;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ sv/pcg32_random_with_range.sv @@
// A request yields a 32-bit word, the raw word for the full 2^32 range, a 64-bit
// word from two draws, or a ranged integer from the serial remainder unit; an
// empty range returns the low bound and an unused code returns zero, without a draw.
// One request at a time: the next can be taken the cycle after the result loads;
// each draw steps through S_MUL0, S_MUL1, S_MUL2 and S_UPD on the shared 32x32 multiplier.
// Synchronous active-low reset clears the seed and reseeds from it; a seed write loads and reseeds.
// ----------------------------------------------------------------------------
// PCG32 random generator with ranged integers
// XSH-RR generator with raw 32/64-bit words and bounded integer requests.
// ----------------------------------------------------------------------------
`default_nettype none

module pcg32_random_with_range (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [1:0]                         i_operation,
    input  wire logic signed [pcg_pkg::WordW-1:0]   i_range_low,
    input  wire logic signed [pcg_pkg::WordW-1:0]   i_range_high,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [pcg_pkg::StateW-1:0]              o_random_value,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [pcg_pkg::StateW-1:0]         i_seed_value
);

    pcg_pkg::t_cmd cmd;
    pcg_pkg::t_sts sts;

    pcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pcg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_seed_value   (i_seed_value),
        .i_operation    (i_operation),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .o_random_value (o_random_value)
    );

    // never overwrite a result that has not been taken
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || i_ready))
        else $error("output register overwritten");

    // only one source writes the LCG state in a cycle
    a_state_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clear_state, cmd.add_seed, cmd.mstep == pcg_pkg::MS_UPD}))
        else $error("conflicting state updates");

    // the remainder unit runs only for a proper ranged request
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> (sts.op == pcg_pkg::OP_RANGE && !sts.empty && !sts.full_range))
        else $error("remainder step outside a ranged request");

    // a seed write and a request are never taken together
    a_one_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && o_ready && i_cfg_valid && o_cfg_ready))
        else $error("request and seed write accepted together");

endmodule

`default_nettype wire
